// ===== design/bitmap_text_rasterizer_defines.svh =====
// ----------------------------------------------------------------------------
// bitmap_text_rasterizer_defines.svh
// Assertion macros used by the rasterizer RTL (btr_scan).
// ----------------------------------------------------------------------------
`ifndef BITMAP_TEXT_RASTERIZER_DEFINES_SVH
`define BITMAP_TEXT_RASTERIZER_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define BTR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("btr assertion failed");
// checked on every edge, reset included
`define BTR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("btr assertion failed");
`else
`define BTR_ASSERT(label, clk, rst, prop)
`define BTR_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== design/btr_pkg.sv =====
// ----------------------------------------------------------------------------
// btr_pkg
// Types, constants and glyph table of the bitmap text rasterizer.
// ----------------------------------------------------------------------------
package btr_pkg;

   localparam int GLYPH_WIDTH   = 5;
   localparam int GLYPH_HEIGHT  = 7;
   localparam int GLYPH_BITS    = GLYPH_WIDTH * GLYPH_HEIGHT;
   localparam int CHAR_ADVANCE  = 6;
   localparam int SPACE_ADVANCE = 3;
   localparam int GLYPH_OTHER   = 41;

   localparam int CHAR_W   = 8;
   localparam int POS_W    = 12;
   localparam int COLOR_W  = 8;
   localparam int CURSOR_W = 16;
   localparam int FRAME_W  = 13;
   localparam int ADDR_W   = 24;
   localparam int PIXEL_W  = 16;
   localparam int GIDX_W   = 6;
   localparam int PY_W     = 3;
   localparam int PX_W     = 3;
   localparam int CSR_IDX_W = 8;

   localparam logic [FRAME_W-1:0] FRAME_WIDTH_RESET  = 13'd1024;
   localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RESET = 13'd600;
   localparam logic [CHAR_W-1:0]  CHAR_SPACE = 8'h20;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_FRAME_WIDTH  = 8'd0;
   localparam csr_index_type CSR_FRAME_HEIGHT = 8'd1;

   typedef logic [GLYPH_BITS-1:0] glyph_mask_type;

   // job handed from the fetch stage to the scan engine
   typedef struct packed {
      glyph_mask_type           mask;   // bit k = dot (k/5, k%5), clipped
      logic [ADDR_W-1:0]        base;   // row * width + column of the glyph origin
      logic [PIXEL_W-1:0]       color;
   } scan_load_type;

   function automatic logic [GIDX_W-1:0] glyph_index(input logic [CHAR_W-1:0] ch_in);
      logic [CHAR_W-1:0] ch;
      logic [GIDX_W-1:0] idx;
      ch = ch_in;
      if (ch inside {[8'h61:8'h7A]}) ch = ch - 8'h20;
      if (ch inside {[8'h30:8'h39]})      idx = GIDX_W'(ch - 8'h30);
      else if (ch inside {[8'h41:8'h5A]}) idx = GIDX_W'(ch - 8'h41 + 8'd10);
      else if (ch == 8'h5B)               idx = 6'd36;
      else if (ch == 8'h5D)               idx = 6'd37;
      else if (ch == 8'h3A)               idx = 6'd38;
      else if (ch == 8'h2E)               idx = 6'd39;
      else if (ch == 8'h3E)               idx = 6'd40;
      else                                idx = GIDX_W'(GLYPH_OTHER);
      return idx;
   endfunction

   // rows top to bottom, MSB of each row is the leftmost column
   function automatic glyph_mask_type glyph_rows(input logic [GIDX_W-1:0] idx);
      glyph_mask_type r;
      case (idx)
         6'd0:  r = {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
         6'd1:  r = {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E};
         6'd2:  r = {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F};
         6'd3:  r = {5'h0E,5'h11,5'h01,5'h06,5'h01,5'h11,5'h0E};
         6'd4:  r = {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02};
         6'd5:  r = {5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E};
         6'd6:  r = {5'h0E,5'h10,5'h1E,5'h11,5'h11,5'h11,5'h0E};
         6'd7:  r = {5'h1F,5'h01,5'h02,5'h04,5'h04,5'h04,5'h04};
         6'd8:  r = {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E};
         6'd9:  r = {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h11,5'h0E};
         6'd10: r = {5'h04,5'h0A,5'h11,5'h1F,5'h11,5'h11,5'h11};
         6'd11: r = {5'h1E,5'h11,5'h1E,5'h11,5'h11,5'h1E,5'h00};
         6'd12: r = {5'h0E,5'h11,5'h10,5'h10,5'h11,5'h0E,5'h00};
         6'd13: r = {5'h1E,5'h11,5'h11,5'h11,5'h11,5'h1E,5'h00};
         6'd14: r = {5'h1F,5'h10,5'h1E,5'h10,5'h10,5'h1F,5'h00};
         6'd15: r = {5'h1F,5'h10,5'h1E,5'h10,5'h10,5'h10,5'h00};
         6'd16: r = {5'h0F,5'h10,5'h17,5'h11,5'h11,5'h0E,5'h00};
         6'd17: r = {5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11,5'h00};
         6'd18: r = {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h1F,5'h00};
         6'd19: r = {5'h07,5'h02,5'h02,5'h02,5'h12,5'h0C,5'h00};
         6'd20: r = {5'h12,5'h14,5'h18,5'h14,5'h12,5'h11,5'h00};
         6'd21: r = {5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F,5'h00};
         6'd22: r = {5'h11,5'h1B,5'h15,5'h11,5'h11,5'h11,5'h00};
         6'd23: r = {5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h00};
         6'd24: r = {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h0E,5'h00};
         6'd25: r = {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h00};
         6'd26: r = {5'h0E,5'h11,5'h11,5'h15,5'h12,5'h0D,5'h00};
         6'd27: r = {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h11,5'h00};
         6'd28: r = {5'h0F,5'h10,5'h0E,5'h01,5'h10,5'h1E,5'h00};
         6'd29: r = {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h00};
         6'd30: r = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E,5'h00};
         6'd31: r = {5'h11,5'h11,5'h11,5'h0A,5'h0A,5'h04,5'h00};
         6'd32: r = {5'h11,5'h11,5'h15,5'h15,5'h1B,5'h11,5'h00};
         6'd33: r = {5'h11,5'h0A,5'h04,5'h04,5'h0A,5'h11,5'h00};
         6'd34: r = {5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04,5'h00};
         6'd35: r = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h1F,5'h00};
         6'd36: r = {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h10};
         6'd37: r = {5'h01,5'h01,5'h01,5'h01,5'h01,5'h01,5'h01};
         6'd38: r = {5'h00,5'h04,5'h04,5'h00,5'h04,5'h04,5'h00};
         6'd39: r = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h04,5'h00};
         6'd40: r = {5'h00,5'h00,5'h01,5'h02,5'h04,5'h08,5'h00};
         default: r = {5'h00,5'h00,5'h04,5'h00,5'h00,5'h00,5'h00};
      endcase
      return r;
   endfunction

endpackage

// ===== design/btr_if.sv =====
// ----------------------------------------------------------------------------
// btr interfaces
// Valid/ready channels of the rasterizer: character in, pixel out, CSR write.
// ----------------------------------------------------------------------------
interface btr_req_if;
   logic                         valid;
   logic                         ready;
   logic [btr_pkg::CHAR_W-1:0]   char_code;
   logic                         first_of_text;
   logic [btr_pkg::POS_W-1:0]    start_x;
   logic [btr_pkg::POS_W-1:0]    start_y;
   logic [btr_pkg::COLOR_W-1:0]  color_red;
   logic [btr_pkg::COLOR_W-1:0]  color_green;
   logic [btr_pkg::COLOR_W-1:0]  color_blue;

   modport source (output valid, char_code, first_of_text, start_x, start_y,
                   color_red, color_green, color_blue, input ready);
   modport sink   (input valid, char_code, first_of_text, start_x, start_y,
                   color_red, color_green, color_blue, output ready);
endinterface

interface btr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [btr_pkg::ADDR_W-1:0]   pixel_address;
   logic [btr_pkg::PIXEL_W-1:0]  pixel_value;
   logic                         write_enable;
   logic                         last_pixel;

   modport source (output valid, pixel_address, pixel_value, write_enable, last_pixel,
                   input ready);
   modport sink   (input valid, pixel_address, pixel_value, write_enable, last_pixel,
                   output ready);
endinterface

interface btr_csr_if;
   logic                           valid;
   logic                           ready;
   logic [btr_pkg::CSR_IDX_W-1:0]  index;
   logic [btr_pkg::FRAME_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/btr_glyph_rom.sv =====
// ----------------------------------------------------------------------------
// btr_glyph_rom
// 42 x 35 bit glyph ROM with a registered read.
// ----------------------------------------------------------------------------
module btr_glyph_rom (
   input  logic                            clock,
   input  logic                            read_en,
   input  logic [btr_pkg::GIDX_W-1:0]      read_index,
   output btr_pkg::glyph_mask_type         read_rows
);

   btr_pkg::glyph_mask_type rows_ff;

   always_ff @(posedge clock) begin
      if (read_en) begin
         rows_ff <= btr_pkg::glyph_rows(read_index);
      end
   end

   assign read_rows = rows_ff;

endmodule

// ===== design/btr_scan.sv =====
// ----------------------------------------------------------------------------
// btr_scan
// Walks the clipped dot mask, one pixel write per cycle while rsp accepts, into an output register.
// ----------------------------------------------------------------------------
`include "bitmap_text_rasterizer_defines.svh"

module btr_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load_valid,
   output logic                          load_ready,
   input  btr_pkg::scan_load_type        load_job,
   input  logic [btr_pkg::FRAME_W-1:0]   frame_width,
   btr_rsp_if.source                     rsp
);

   logic                          busy_ff, busy_in;
   btr_pkg::glyph_mask_type       mask_ff, mask_in;
   logic [btr_pkg::ADDR_W-1:0]    base_ff;
   logic [btr_pkg::PIXEL_W-1:0]   color_ff;

   logic                          out_valid_ff, out_valid_in;
   logic [btr_pkg::ADDR_W-1:0]    out_addr_ff;
   logic [btr_pkg::PIXEL_W-1:0]   out_value_ff;
   logic                          out_we_ff;
   logic                          out_last_ff;

   logic                          emit;
   logic                          emit_last;
   logic                          load;
   btr_pkg::glyph_mask_type       mask_rest;
   logic [btr_pkg::PY_W-1:0]      sel_py;
   logic [btr_pkg::PX_W-1:0]      sel_px;
   logic [btr_pkg::ADDR_W-1:0]    pix_addr;

   // lowest set bit is the next dot in raster order
   always_comb begin
      sel_py = '0;
      sel_px = '0;
      for (int py = btr_pkg::GLYPH_HEIGHT - 1; py >= 0; py--) begin
         for (int px = btr_pkg::GLYPH_WIDTH - 1; px >= 0; px--) begin
            if (mask_ff[py * btr_pkg::GLYPH_WIDTH + px]) begin
               sel_py = btr_pkg::PY_W'(py);
               sel_px = btr_pkg::PX_W'(px);
            end
         end
      end
   end

   assign mask_rest = mask_ff & (mask_ff - btr_pkg::GLYPH_BITS'(1));
   assign pix_addr  = base_ff
                    + btr_pkg::ADDR_W'(sel_py * frame_width)
                    + btr_pkg::ADDR_W'(sel_px);

   assign emit       = busy_ff && (!out_valid_ff || rsp.ready);
   assign emit_last  = (mask_ff == '0) || (mask_rest == '0);
   assign load_ready = !busy_ff || (emit && emit_last);
   assign load       = load_valid && load_ready;

   always_comb begin
      busy_in      = busy_ff;
      mask_in      = mask_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp.ready) out_valid_in = 1'b0;
      if (emit) begin
         out_valid_in = 1'b1;
         mask_in      = mask_rest;
         if (emit_last) busy_in = 1'b0;
      end
      if (load) begin
         busy_in = 1'b1;
         mask_in = load_job.mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      if (load) begin
         base_ff  <= load_job.base;
         color_ff <= load_job.color;
      end
      if (emit) begin
         out_last_ff <= emit_last;
         if (mask_ff == '0) begin
            out_addr_ff  <= '0;
            out_value_ff <= '0;
            out_we_ff    <= 1'b0;
         end else begin
            out_addr_ff  <= pix_addr;
            out_value_ff <= color_ff;
            out_we_ff    <= 1'b1;
         end
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.pixel_address = out_addr_ff;
   assign rsp.pixel_value   = out_value_ff;
   assign rsp.write_enable  = out_we_ff;
   assign rsp.last_pixel    = out_last_ff;

   `BTR_ASSERT(a_empty_is_last, clock, reset, (emit && mask_ff == '0) |-> emit_last)
   `BTR_ASSERT(a_nowrite_is_last, clock, reset, (out_valid_ff && !out_we_ff) |-> out_last_ff)
   `BTR_ASSERT(a_mask_holds, clock, reset, (busy_ff && !emit) |=> $stable(mask_ff))
   `BTR_ASSERT(a_free_after_last, clock, reset,
      (emit && emit_last && !load_valid) |=> !busy_ff)
   `BTR_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!busy_ff && !out_valid_ff))

endmodule

// ===== design/bitmap_text_rasterizer.sv =====
// ----------------------------------------------------------------------------
// bitmap_text_rasterizer
// 5x7 character generator producing RGB565 framebuffer writes.
// ----------------------------------------------------------------------------
// Usage:
//  req  : one character per transfer. first_of_text = 1 loads the text origin
//         (start_x, start_y) and the RGB888 color (kept as RGB565).
//  rsp  : one framebuffer write per set, in-frame glyph dot, raster order;
//         last_pixel flags the final transfer of a character. A space or a
//         fully clipped glyph gives one transfer with write_enable = 0.
//  csr  : index 0 frame_width, 1 frame_height; other indexes are dropped.
//         Always ready; write only while the block is idle.
// Timing: a first result passes the fetch stage, scan engine and output
//  register. A character occupies the scan engine for max(1, dots)
//  transfers, at most 35; the next character is fetched from the glyph ROM
//  while the current one scans, so characters stream with no bubbles.
// Reset: cursor, row and color go to zero, width 1024, height 600; all
//  pipeline stages empty.
// Stall: when rsp is not ready the output register holds, the scan engine
//  stops, and req.ready drops once the fetch stage is full.
// ----------------------------------------------------------------------------
module bitmap_text_rasterizer (
   input  logic        clock,
   input  logic        reset,
   btr_req_if.sink     req_bus,
   btr_rsp_if.source   rsp_bus,
   btr_csr_if.sink     csr_bus
);

   // configuration
   logic [btr_pkg::FRAME_W-1:0]   frame_width_ff, frame_width_in;
   logic [btr_pkg::FRAME_W-1:0]   frame_height_ff, frame_height_in;

   // text state, updated at the req transfer so the next character sees it
   logic [btr_pkg::CURSOR_W-1:0]  cursor_ff, cursor_in;
   logic [btr_pkg::POS_W-1:0]     row_ff, row_in;
   logic [btr_pkg::PIXEL_W-1:0]   color_ff, color_in;

   // fetch stage: waits for the registered ROM read
   logic                          fetch_valid_ff, fetch_valid_in;
   logic [btr_pkg::CURSOR_W-1:0]  fetch_col_ff;
   logic [btr_pkg::POS_W-1:0]     fetch_row_ff;
   logic [btr_pkg::PIXEL_W-1:0]   fetch_color_ff;
   logic                          fetch_space_ff;

   logic                          accept;
   logic                          is_space;
   logic [btr_pkg::CURSOR_W:0]    cursor_sum;
   btr_pkg::glyph_mask_type       rom_rows;
   btr_pkg::scan_load_type        job;
   logic                          scan_ready;
   logic [btr_pkg::GLYPH_WIDTH-1:0]  col_ok;
   logic [btr_pkg::GLYPH_HEIGHT-1:0] row_ok;

   assign accept   = req_bus.valid && req_bus.ready;
   assign is_space = (req_bus.char_code == btr_pkg::CHAR_SPACE);
   assign req_bus.ready = !fetch_valid_ff || scan_ready;
   assign csr_bus.ready = 1'b1;

   // CSR writes
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            btr_pkg::CSR_FRAME_WIDTH:  frame_width_in  = csr_bus.data;
            btr_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_bus.data;
            default: ;
         endcase
      end
   end

   // origin latch and cursor advance
   always_comb begin
      cursor_in = cursor_ff;
      row_in    = row_ff;
      color_in  = color_ff;
      if (req_bus.first_of_text) begin
         cursor_in = btr_pkg::CURSOR_W'(req_bus.start_x);
         row_in    = req_bus.start_y;
         color_in  = {req_bus.color_red[7:3], req_bus.color_green[7:2],
                      req_bus.color_blue[7:3]};
      end
      cursor_sum = {1'b0, cursor_in}
                 + (is_space ? (btr_pkg::CURSOR_W + 1)'(btr_pkg::SPACE_ADVANCE)
                             : (btr_pkg::CURSOR_W + 1)'(btr_pkg::CHAR_ADVANCE));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= btr_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= btr_pkg::FRAME_HEIGHT_RESET;
         cursor_ff       <= '0;
         row_ff          <= '0;
         color_ff        <= '0;
         fetch_valid_ff  <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         fetch_valid_ff  <= fetch_valid_in;
         if (accept) begin
            // saturate at the top of the cursor range
            cursor_ff <= cursor_sum[btr_pkg::CURSOR_W] ? '1
                                                       : cursor_sum[btr_pkg::CURSOR_W-1:0];
            row_ff    <= row_in;
            color_ff  <= color_in;
         end
      end
   end

   always_comb begin
      fetch_valid_in = fetch_valid_ff;
      if (scan_ready) fetch_valid_in = 1'b0;
      if (accept)     fetch_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fetch_col_ff   <= cursor_in;
         fetch_row_ff   <= row_in;
         fetch_color_ff <= color_in;
         fetch_space_ff <= is_space;
      end
   end

   btr_glyph_rom u_rom (
      .clock      (clock),
      .read_en    (accept),
      .read_index (btr_pkg::glyph_index(req_bus.char_code)),
      .read_rows  (rom_rows)
   );

   // clip each glyph column and row against the frame
   always_comb begin
      for (int px = 0; px < btr_pkg::GLYPH_WIDTH; px++) begin
         col_ok[px] = ({1'b0, fetch_col_ff} + (btr_pkg::CURSOR_W + 1)'(px))
                    < (btr_pkg::CURSOR_W + 1)'(frame_width_ff);
      end
      for (int py = 0; py < btr_pkg::GLYPH_HEIGHT; py++) begin
         row_ok[py] = ({1'b0, fetch_row_ff} + btr_pkg::FRAME_W'(py)) < frame_height_ff;
      end
   end

   // mask bit k is dot (k / 5, k % 5); ROM bit order is the reverse
   always_comb begin
      for (int py = 0; py < btr_pkg::GLYPH_HEIGHT; py++) begin
         for (int px = 0; px < btr_pkg::GLYPH_WIDTH; px++) begin
            job.mask[py * btr_pkg::GLYPH_WIDTH + px] =
               rom_rows[btr_pkg::GLYPH_BITS - 1 - (py * btr_pkg::GLYPH_WIDTH + px)]
               && col_ok[px] && row_ok[py] && !fetch_space_ff;
         end
      end
      job.base  = btr_pkg::ADDR_W'(fetch_row_ff * frame_width_ff)
                + btr_pkg::ADDR_W'(fetch_col_ff);
      job.color = fetch_color_ff;
   end

   btr_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .load_valid  (fetch_valid_ff),
      .load_ready  (scan_ready),
      .load_job    (job),
      .frame_width (frame_width_ff),
      .rsp         (rsp_bus)
   );

endmodule

// ===== dv/bitmap_text_rasterizer_tb.sv =====
// ----------------------------------------------------------------------------
// bitmap_text_rasterizer_tb
// Self-checking bench for the 5x7 text rasterizer. Characters go in on the
// req channel with random gaps, pixel writes are taken off the rsp channel
// with random stalls, and every transfer out is matched in order against a
// local glyph predictor. Frame size is changed between phases through csr.
// ----------------------------------------------------------------------------
module bitmap_text_rasterizer_tb;
   import btr_pkg::*;

   // csr indexes with no register behind them; writes there must be dropped
   localparam csr_index_type CSR_UNMAPPED     = 8'd2;
   localparam csr_index_type CSR_UNMAPPED_TOP = 8'hFF;

   // font slots past the alphanumerics
   localparam int SLOT_LBRACKET = 36;
   localparam int SLOT_RBRACKET = 37;
   localparam int SLOT_COLON    = 38;
   localparam int SLOT_PERIOD   = 39;
   localparam int SLOT_GREATER  = 40;

   localparam int IDLE_PCT      = 24;
   localparam int HOLD_CYCLES   = 400;   // long rsp back-pressure stretch
   localparam int SETTLE_CYCLES = 8;     // quiet gap before csr writes
   localparam int DRAIN_LIMIT   = 200000;
   localparam int TAIL_CYCLES   = 20;

   // 5x7 font, row 0 first, MSB of each row is the leftmost column
   localparam logic [GLYPH_BITS-1:0] FONT [42] = '{
      {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E}, {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E},
      {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F}, {5'h0E,5'h11,5'h01,5'h06,5'h01,5'h11,5'h0E},
      {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02}, {5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E},
      {5'h0E,5'h10,5'h1E,5'h11,5'h11,5'h11,5'h0E}, {5'h1F,5'h01,5'h02,5'h04,5'h04,5'h04,5'h04},
      {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E}, {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h11,5'h0E},
      {5'h04,5'h0A,5'h11,5'h1F,5'h11,5'h11,5'h11}, {5'h1E,5'h11,5'h1E,5'h11,5'h11,5'h1E,5'h00},
      {5'h0E,5'h11,5'h10,5'h10,5'h11,5'h0E,5'h00}, {5'h1E,5'h11,5'h11,5'h11,5'h11,5'h1E,5'h00},
      {5'h1F,5'h10,5'h1E,5'h10,5'h10,5'h1F,5'h00}, {5'h1F,5'h10,5'h1E,5'h10,5'h10,5'h10,5'h00},
      {5'h0F,5'h10,5'h17,5'h11,5'h11,5'h0E,5'h00}, {5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11,5'h00},
      {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h1F,5'h00}, {5'h07,5'h02,5'h02,5'h02,5'h12,5'h0C,5'h00},
      {5'h12,5'h14,5'h18,5'h14,5'h12,5'h11,5'h00}, {5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F,5'h00},
      {5'h11,5'h1B,5'h15,5'h11,5'h11,5'h11,5'h00}, {5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h00},
      {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h0E,5'h00}, {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h00},
      {5'h0E,5'h11,5'h11,5'h15,5'h12,5'h0D,5'h00}, {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h11,5'h00},
      {5'h0F,5'h10,5'h0E,5'h01,5'h10,5'h1E,5'h00}, {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h00},
      {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E,5'h00}, {5'h11,5'h11,5'h11,5'h0A,5'h0A,5'h04,5'h00},
      {5'h11,5'h11,5'h15,5'h15,5'h1B,5'h11,5'h00}, {5'h11,5'h0A,5'h04,5'h04,5'h0A,5'h11,5'h00},
      {5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04,5'h00}, {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h1F,5'h00},
      {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h10}, {5'h01,5'h01,5'h01,5'h01,5'h01,5'h01,5'h01},
      {5'h00,5'h04,5'h04,5'h00,5'h04,5'h04,5'h00}, {5'h00,5'h00,5'h00,5'h00,5'h00,5'h04,5'h00},
      {5'h00,5'h00,5'h01,5'h02,5'h04,5'h08,5'h00}, {5'h00,5'h00,5'h04,5'h00,5'h00,5'h00,5'h00}
   };

   typedef struct {
      logic [CHAR_W-1:0]  code;
      logic               first;
      logic [POS_W-1:0]   x;
      logic [POS_W-1:0]   y;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } char_req_type;

   typedef struct {
      logic [ADDR_W-1:0]  addr;
      logic [PIXEL_W-1:0] value;
      logic               we;
      logic               last;
   } pixel_wr_type;

   // lower case folds onto upper case; anything unknown gets the lone dot
   function automatic int font_slot(input logic [CHAR_W-1:0] code);
      logic [CHAR_W-1:0] c;
      c = (code >= "a" && code <= "z") ? code - 8'd32 : code;
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "A" && c <= "Z") return int'(c - "A") + 10;
      case (c)
         "[":     return SLOT_LBRACKET;
         "]":     return SLOT_RBRACKET;
         ":":     return SLOT_COLON;
         ".":     return SLOT_PERIOD;
         ">":     return SLOT_GREATER;
         default: return GLYPH_OTHER;
      endcase
   endfunction

   function automatic logic [CURSOR_W-1:0] bump_cursor(input logic [CURSOR_W-1:0] col,
                                                       input int step);
      int unsigned moved;
      moved = col + step;
      return (moved > 65535) ? 16'hFFFF : CURSOR_W'(moved);
   endfunction

   // ------------------------------------------------------------------------
   // Glyph predictor plus in-order check of the pixel stream
   // ------------------------------------------------------------------------
   class glyph_scoreboard;
      logic [FRAME_W-1:0]  width;
      logic [FRAME_W-1:0]  height;
      logic [CURSOR_W-1:0] cursor;
      logic [POS_W-1:0]    row;
      logic [PIXEL_W-1:0]  color;
      pixel_wr_type        due_pixels[$];
      int unsigned         errors;
      int unsigned         n_chars;
      int unsigned         n_writes;
      int unsigned         n_blank;

      function new();
         width    = FRAME_WIDTH_RESET;
         height   = FRAME_HEIGHT_RESET;
         cursor   = '0;
         row      = '0;
         color    = '0;
         errors   = 0;
         n_chars  = 0;
         n_writes = 0;
         n_blank  = 0;
      endfunction

      task report(input string what);
         errors++;
         $display("MISMATCH: %s", what);
      endtask

      function void set_reg(input csr_index_type idx, input logic [FRAME_W-1:0] value);
         case (idx)
            CSR_FRAME_WIDTH:  width = value;
            CSR_FRAME_HEIGHT: height = value;
            default: ;
         endcase
      endfunction

      // expected writes of one accepted character, raster order
      function void draw_char(input char_req_type item);
         logic [GLYPH_BITS-1:0] dots;
         pixel_wr_type          w;
         int unsigned           col, line, produced;
         int                    py, px;
         longint unsigned       addr;
         n_chars++;
         if (item.first) begin
            cursor = CURSOR_W'(item.x);
            row    = item.y;
            color  = {item.red[7:3], item.green[7:2], item.blue[7:3]};
         end
         produced = 0;
         if (item.code == CHAR_SPACE) begin
            cursor = bump_cursor(cursor, SPACE_ADVANCE);
         end else begin
            dots = FONT[font_slot(item.code)];
            for (py = 0; py < GLYPH_HEIGHT; py++) begin
               for (px = 0; px < GLYPH_WIDTH; px++) begin
                  if (dots[GLYPH_BITS-1 - (py*GLYPH_WIDTH + px)]) begin
                     col  = cursor + px;
                     line = row + py;
                     if (col < width && line < height) begin
                        addr    = line;
                        addr    = addr * width + col;
                        w.addr  = addr[ADDR_W-1:0];
                        w.value = color;
                        w.we    = 1'b1;
                        w.last  = 1'b0;
                        due_pixels.push_back(w);
                        produced++;
                     end
                  end
               end
            end
            cursor = bump_cursor(cursor, CHAR_ADVANCE);
         end
         if (produced == 0) begin
            w.addr  = '0;
            w.value = '0;
            w.we    = 1'b0;
            w.last  = 1'b1;
            due_pixels.push_back(w);
            n_blank++;
         end else begin
            w = due_pixels.pop_back();
            w.last = 1'b1;
            due_pixels.push_back(w);
            n_writes += produced;
         end
      endfunction

      task check_pixel(input pixel_wr_type got);
         pixel_wr_type want;
         if (due_pixels.size() == 0) begin
            report($sformatf("unexpected transfer addr %h value %h we %b last %b",
                             got.addr, got.value, got.we, got.last));
            return;
         end
         want = due_pixels.pop_front();
         if (got.addr !== want.addr)
            report($sformatf("pixel_address %h, expected %h", got.addr, want.addr));
         if (got.value !== want.value)
            report($sformatf("pixel_value %h, expected %h (addr %h)",
                             got.value, want.value, want.addr));
         if (got.we !== want.we)
            report($sformatf("write_enable %b, expected %b (addr %h)",
                             got.we, want.we, want.addr));
         if (got.last !== want.last)
            report($sformatf("last_pixel %b, expected %b (addr %h)",
                             got.last, want.last, want.addr));
      endtask
   endclass

   // ------------------------------------------------------------------------
   // Clock, reset, channels, DUT
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   btr_req_if req_if ();
   btr_rsp_if rsp_if ();
   btr_csr_if csr_if ();

   bitmap_text_rasterizer u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   glyph_scoreboard board;

   logic        calm = 1'b0;    // 1 = neither side idles
   int          hold_seq = 0;   // bumped by stimulus to request a long rsp hold-off
   int          hold_seen = 0;
   int          hold_left = 0;
   int unsigned n_settings = 0;

   // ------------------------------------------------------------------------
   // Result side: check every transfer, stall at random or for a long
   // stretch on request. All samples are pre-edge values since every driver
   // in the bench and the DUT updates through nonblocking assignments.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_side
      pixel_wr_type got;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.addr  = rsp_if.pixel_address;
            got.value = rsp_if.pixel_value;
            got.we    = rsp_if.write_enable;
            got.last  = rsp_if.last_pixel;
            board.check_pixel(got);
         end
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic char_req_type char_item(input logic [CHAR_W-1:0] code,
                                              input logic first,
                                              input logic [POS_W-1:0] x, y,
                                              input logic [COLOR_W-1:0] red, green, blue);
      char_req_type item;
      item.code  = code;
      item.first = first;
      item.x     = x;
      item.y     = y;
      item.red   = red;
      item.green = green;
      item.blue  = blue;
      return item;
   endfunction

   // mostly printable text, with spaces, the punctuation glyphs and raw bytes
   function automatic logic [CHAR_W-1:0] random_char();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 22) return CHAR_W'($urandom_range("A", "Z"));
      if (pick < 37) return CHAR_W'($urandom_range("a", "z"));
      if (pick < 50) return CHAR_W'($urandom_range("0", "9"));
      if (pick < 60) begin
         case ($urandom_range(4))
            0:       return "[";
            1:       return "]";
            2:       return ":";
            3:       return ".";
            default: return ">";
         endcase
      end
      if (pick < 75) return CHAR_SPACE;
      return CHAR_W'($urandom_range(255));
   endfunction

   // text origin: often straddling the frame edge so clipping gets exercised
   function automatic logic [POS_W-1:0] pick_pos(input int unsigned limit);
      int v;
      case ($urandom_range(3))
         0, 1:    v = int'(limit) - 8 + int'($urandom_range(12));
         2:       v = int'($urandom_range((limit > 4095) ? 4095 : limit));
         default: v = int'($urandom_range(4095));
      endcase
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return POS_W'(v);
   endfunction

   task automatic send_char(input char_req_type item);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.char_code     <= item.code;
      req_if.first_of_text <= item.first;
      req_if.start_x       <= item.x;
      req_if.start_y       <= item.y;
      req_if.color_red     <= item.red;
      req_if.color_green   <= item.green;
      req_if.color_blue    <= item.blue;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      board.draw_char(item);
   endtask

   // stop offering and wait for every predicted pixel to come out
   task automatic wait_drained();
      int unsigned waited;
      waited = 0;
      req_if.valid <= 1'b0;
      while (board.due_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [FRAME_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      board.set_reg(idx, value);
      @(posedge clock);
   endtask

   // frame size only changes with the block drained and quiet
   task automatic set_frame(input logic [FRAME_W-1:0] w, input logic [FRAME_W-1:0] h);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
      n_settings++;
   endtask

   // short texts: one origin-setting character, then a run that reuses it
   task automatic random_texts(input int unsigned n_items);
      int unsigned start, len, k;
      start = board.n_chars;
      while (board.n_chars - start < n_items) begin
         len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 12);
         send_char(char_item(random_char(), 1'b1, pick_pos(board.width),
                             pick_pos(board.height), CHAR_W'($urandom),
                             CHAR_W'($urandom), CHAR_W'($urandom)));
         for (k = 1; k < len; k++)
            send_char(char_item(random_char(), 1'b0, POS_W'($urandom), POS_W'($urandom),
                                CHAR_W'($urandom), CHAR_W'($urandom), CHAR_W'($urandom)));
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      board = new();
      req_if.valid         <= 1'b0;
      req_if.char_code     <= '0;
      req_if.first_of_text <= 1'b0;
      req_if.start_x       <= '0;
      req_if.start_y       <= '0;
      req_if.color_red     <= '0;
      req_if.color_green   <= '0;
      req_if.color_blue    <= '0;
      csr_if.valid         <= 1'b0;
      csr_if.index         <= '0;
      csr_if.data          <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // -- directed, reset frame 1024x600 --
      // no origin latched yet: draws at 0,0 in black, start fields ignored
      send_char(char_item("B", 1'b0, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF));
      send_char(char_item("A", 1'b1, 12'd0, 12'd0, 8'hFF, 8'hFF, 8'hFF));
      send_char(char_item("a", 1'b0, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00));
      send_char(char_item("0", 1'b0, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00));
      send_char(char_item("9", 1'b0, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00));
      send_char(char_item("Z", 1'b0, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00));
      send_char(char_item("z", 1'b0, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00));
      send_char(char_item("[", 1'b0, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00));
      send_char(char_item("]", 1'b0, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00));
      send_char(char_item(":", 1'b0, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00));
      send_char(char_item(".", 1'b0, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00));
      send_char(char_item(">", 1'b0, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00));
      send_char(char_item(CHAR_SPACE, 1'b0, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00));
      // unknown bytes, low and high half, all take the single-dot glyph
      send_char(char_item(8'h00, 1'b0, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00));
      send_char(char_item(8'hFF, 1'b0, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00));
      send_char(char_item(8'h80, 1'b0, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00));
      send_char(char_item("@", 1'b0, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00));
      send_char(char_item("{", 1'b0, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00));
      // color rounding: lowest bit kept in each channel, then all dropped
      send_char(char_item("M", 1'b1, 12'd1020, 12'd595, 8'h08, 8'h04, 8'h08));
      send_char(char_item("W", 1'b1, 12'd3, 12'd599, 8'h07, 8'h03, 8'h07));
      // glyph wholly past the right edge / past both edges: blank transfer
      send_char(char_item("8", 1'b1, 12'd1024, 12'd10, 8'hFF, 8'h00, 8'hFF));
      send_char(char_item("1", 1'b1, 12'hFFF, 12'hFFF, 8'h00, 8'hFF, 8'h00));

      // -- widest 13-bit frame: row * width + column wraps past 24 bits --
      wait_drained();
      write_reg(CSR_UNMAPPED, 13'h1FFF);
      set_frame(13'h1FFF, 13'h1FFF);
      send_char(char_item("8", 1'b1, 12'hFFF, 12'hFFF, 8'hF8, 8'hFC, 8'hF8));
      send_char(char_item("[", 1'b1, 12'd4090, 12'd4094, 8'h55, 8'hAA, 8'h55));
      random_texts(60);

      // -- single-pixel frame --
      set_frame(13'd1, 13'd1);
      random_texts(40);

      // -- zero-sized frames suppress every write --
      set_frame(13'd0, 13'd600);
      random_texts(15);
      set_frame(13'd4096, 13'd0);
      random_texts(15);

      // -- 4096x4096, with a long rsp hold-off and a full drain mid-stream --
      set_frame(13'd4096, 13'd4096);
      random_texts(40);
      hold_seq <= hold_seq + 1;
      random_texts(40);
      wait_drained();
      random_texts(30);

      // -- random frame with neither side idling --
      calm <= 1'b1;
      set_frame(FRAME_W'($urandom_range(1, 4096)), FRAME_W'($urandom_range(1, 4096)));
      random_texts(80);
      wait_drained();
      calm <= 1'b0;

      // -- small random frame, unmapped csr write alongside --
      write_reg(CSR_UNMAPPED_TOP, FRAME_W'($urandom));
      set_frame(FRAME_W'($urandom_range(1, 64)), FRAME_W'($urandom_range(1, 64)));
      random_texts(80);

      // -- back to the reset geometry --
      set_frame(FRAME_WIDTH_RESET, FRAME_HEIGHT_RESET);
      random_texts(60);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.due_pixels.size() != 0)
         board.report($sformatf("%0d expected transfers never arrived",
                                board.due_pixels.size()));

      $display("Drew %0d characters over %0d frame geometries (reset one included).",
               board.n_chars, n_settings + 1);
      $display("Checked %0d pixel writes and %0d blank transfers, %0d mismatches.",
               board.n_writes, board.n_blank, board.errors);
      if (board.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin : watchdog
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/btr_pkg.sv
design/btr_if.sv
design/btr_glyph_rom.sv
design/btr_scan.sv
design/bitmap_text_rasterizer.sv
dv/bitmap_text_rasterizer_tb.sv
